// ===== hw/rtl/point_box_crop_transform_assert.svh =====
// Assertion shorthands for the crop/transform block.
`ifndef POINT_BOX_CROP_TRANSFORM_ASSERT_SVH
`define POINT_BOX_CROP_TRANSFORM_ASSERT_SVH

// same-cycle implication, off during reset
`define PBCT_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("pbct assertion failed");

// next-cycle implication, off during reset
`define PBCT_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("pbct assertion failed");

// next-cycle implication, always checked
`define PBCT_ASSERT_ALWAYS(label, ante, cons) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("pbct assertion failed");

`endif

// ===== hw/rtl/pbct_pkg.sv =====
package pbct_pkg;

   localparam int BOX_SLOTS = 8;
   localparam int COORD_W   = 32;
   localparam int PROD_W    = 2 * COORD_W;

   localparam logic [1:0] OP_BOX_WRITE = 2'd0;
   localparam logic [1:0] OP_ROW_WRITE = 2'd1;
   localparam logic [1:0] OP_POINT     = 2'd2;

   localparam logic [1:0] REG_BOX_COUNT        = 2'd0;
   localparam logic [1:0] REG_FILTER_ENABLE    = 2'd1;
   localparam logic [1:0] REG_TRANSFORM_ENABLE = 2'd2;

   localparam logic signed [COORD_W-1:0] Q_ONE = 32'sh0001_0000;
   localparam int ROWS = 3;

   typedef struct packed {
      logic                      valid;
      logic [2:0]                slot;
      logic                      excludes;
      logic signed [COORD_W-1:0] low_x;
      logic signed [COORD_W-1:0] low_y;
      logic signed [COORD_W-1:0] low_z;
      logic signed [COORD_W-1:0] high_x;
      logic signed [COORD_W-1:0] high_y;
      logic signed [COORD_W-1:0] high_z;
   } box_write_type;

endpackage

// ===== hw/rtl/point_box_crop_transform.sv =====
// Point crop-box filter with affine transform.
// req_* carries one beat per item: op selects a box slot write, a matrix row
// write or a point. Table writes take effect for every later beat at once and
// give no result. A point is tested against slots 0..min(box_count,8)-1 in parallel;
// a dropped point gives no result. A kept point leaves on rsp_* as out_x/y/z,
// mapped through the 3x4 matrix (round half up, saturating) when
// transform_enable is set.
// Throughput: one beat per cycle unless rsp_* stalls. Three register stages
// (box compare, nine 32x32 multiplies, sum/round/saturate), one stage each.
// Stalls: all stages move together; when rsp_valid is high and rsp_ready low,
// the pipeline freezes and req_ready drops, so nothing is lost or repeated.
// Bubbles (dropped points, table writes) freeze with the rest during a stall.
// Reset (synchronous): pipeline empties, matrix to identity, translation to
// zero, box_count 0, both enables 1. Box slots are not cleared.
// csr_*: single-cycle writes, index 0 box_count, 1 filter_enable,
// 2 transform_enable; write only while idle.
module point_box_crop_transform
   import pbct_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [1:0]                req_op,
   input  logic [2:0]                req_slot,
   input  logic                      req_box_excludes,
   input  logic signed [COORD_W-1:0] req_coord_x,
   input  logic signed [COORD_W-1:0] req_coord_y,
   input  logic signed [COORD_W-1:0] req_coord_z,
   input  logic signed [COORD_W-1:0] req_upper_x,
   input  logic signed [COORD_W-1:0] req_upper_y,
   input  logic signed [COORD_W-1:0] req_upper_z,
   input  logic signed [COORD_W-1:0] req_row_offset,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic signed [COORD_W-1:0] rsp_out_x,
   output logic signed [COORD_W-1:0] rsp_out_y,
   output logic signed [COORD_W-1:0] rsp_out_z,
   input  logic                      csr_write_enable,
   input  logic [1:0]                csr_index,
   input  logic [3:0]                csr_write_data
);

   // config
   logic [3:0] box_count_ff;
   logic       filter_en_ff;
   logic       xform_en_ff;

   // live transform
   logic signed [COORD_W-1:0] mat_ff   [9];
   logic signed [COORD_W-1:0] trans_ff [ROWS];

   // stage 1: point, snapshot of the transform
   logic                      s1_valid_ff;
   logic                      s1_xf_ff;
   logic signed [COORD_W-1:0] s1_p_ff [ROWS];
   logic signed [COORD_W-1:0] s1_m_ff [9];
   logic signed [COORD_W-1:0] s1_t_ff [ROWS];

   // stage 2: products
   logic                      s2_valid_ff;
   logic                      s2_xf_ff;
   logic signed [COORD_W-1:0] s2_p_ff    [ROWS];
   logic signed [PROD_W-1:0]  s2_prod_ff [9];
   logic signed [COORD_W-1:0] s2_t_ff    [ROWS];

   // stage 3: output
   logic                      s3_valid_ff;
   logic signed [COORD_W-1:0] s3_out_ff [ROWS];
   logic signed [COORD_W-1:0] s3_out_in [ROWS];

   logic                      advance;
   logic                      accept;
   logic                      keep_box;
   logic                      point_kept;
   logic signed [COORD_W-1:0] req_p [ROWS];
   box_write_type             box_write;

   assign advance   = !s3_valid_ff || rsp_ready;
   assign req_ready = advance;
   assign accept    = req_valid && advance;

   assign req_p[0] = req_coord_x;
   assign req_p[1] = req_coord_y;
   assign req_p[2] = req_coord_z;

   always_comb begin
      box_write.valid    = accept && (req_op == OP_BOX_WRITE) &&
                           (int'(req_slot) < BOX_SLOTS);
      box_write.slot     = req_slot;
      box_write.excludes = req_box_excludes;
      box_write.low_x    = req_coord_x;
      box_write.low_y    = req_coord_y;
      box_write.low_z    = req_coord_z;
      box_write.high_x   = req_upper_x;
      box_write.high_y   = req_upper_y;
      box_write.high_z   = req_upper_z;
   end

   // compare against the slots as written by all earlier beats
   pbct_box_filter u_box_filter (
      .clock     (clock),
      .box_write (box_write),
      .box_count (box_count_ff),
      .point_x   (req_coord_x),
      .point_y   (req_coord_y),
      .point_z   (req_coord_z),
      .keep      (keep_box)
   );

   assign point_kept = !filter_en_ff || keep_box;

   always_ff @(posedge clock) begin
      if (reset) begin
         box_count_ff <= '0;
         filter_en_ff <= 1'b1;
         xform_en_ff  <= 1'b1;
      end else if (csr_write_enable) begin
         case (csr_index)
            REG_BOX_COUNT:        box_count_ff <= csr_write_data;
            REG_FILTER_ENABLE:    filter_en_ff <= csr_write_data[0];
            REG_TRANSFORM_ENABLE: xform_en_ff  <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 9; i++) begin
            mat_ff[i] <= (i % 4 == 0) ? Q_ONE : '0;
         end
         for (int r = 0; r < ROWS; r++) begin
            trans_ff[r] <= '0;
         end
      end else if (accept && (req_op == OP_ROW_WRITE)) begin
         for (int r = 0; r < ROWS; r++) begin
            if (int'(req_slot) == r) begin
               mat_ff[r*3]   <= req_coord_x;
               mat_ff[r*3+1] <= req_coord_y;
               mat_ff[r*3+2] <= req_coord_z;
               trans_ff[r]   <= req_row_offset;
            end
         end
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_valid && (req_op == OP_POINT) && point_kept;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (advance) begin
         s1_xf_ff <= xform_en_ff;
         for (int r = 0; r < ROWS; r++) begin
            s1_p_ff[r] <= req_p[r];
            s1_t_ff[r] <= trans_ff[r];
         end
         for (int i = 0; i < 9; i++) begin
            s1_m_ff[i] <= mat_ff[i];
         end

         s2_xf_ff <= s1_xf_ff;
         for (int r = 0; r < ROWS; r++) begin
            s2_p_ff[r] <= s1_p_ff[r];
            s2_t_ff[r] <= s1_t_ff[r];
            for (int c = 0; c < ROWS; c++) begin
               s2_prod_ff[r*3+c] <= s1_m_ff[r*3+c] * s1_p_ff[c];
            end
         end

         for (int r = 0; r < ROWS; r++) begin
            s3_out_ff[r] <= s3_out_in[r];
         end
      end
   end

   // row sum, round half up, translate, saturate; the point passes unchanged when the transform is off
   always_comb begin
      logic signed [PROD_W+1:0]  sum;
      logic signed [PROD_W-15:0] total;
      for (int r = 0; r < ROWS; r++) begin
         sum = (PROD_W+2)'(s2_prod_ff[r*3]) + (PROD_W+2)'(s2_prod_ff[r*3+1]) +
               (PROD_W+2)'(s2_prod_ff[r*3+2]) + (PROD_W+2)'(32'sh8000);
         total = (PROD_W-14)'(sum >>> 16) + (PROD_W-14)'(s2_t_ff[r]);
         if (!s2_xf_ff) begin
            s3_out_in[r] = s2_p_ff[r];
         end else if (total > (PROD_W-14)'(32'sh7FFF_FFFF)) begin
            s3_out_in[r] = 32'sh7FFF_FFFF;
         end else if (total < -(PROD_W-14)'(33'sh0_8000_0000)) begin
            s3_out_in[r] = -32'sh8000_0000;
         end else begin
            s3_out_in[r] = COORD_W'(total);
         end
      end
   end

   assign rsp_valid = s3_valid_ff;
   assign rsp_out_x = s3_out_ff[0];
   assign rsp_out_y = s3_out_ff[1];
   assign rsp_out_z = s3_out_ff[2];

endmodule

// ===== hw/rtl/pbct_box_filter.sv =====
module pbct_box_filter
   import pbct_pkg::*;
(
   input  logic                      clock,
   input  box_write_type             box_write,
   input  logic [3:0]                box_count,
   input  logic signed [COORD_W-1:0] point_x,
   input  logic signed [COORD_W-1:0] point_y,
   input  logic signed [COORD_W-1:0] point_z,
   output logic                      keep
);

   logic signed [COORD_W-1:0] low_x_ff  [BOX_SLOTS];
   logic signed [COORD_W-1:0] low_y_ff  [BOX_SLOTS];
   logic signed [COORD_W-1:0] low_z_ff  [BOX_SLOTS];
   logic signed [COORD_W-1:0] high_x_ff [BOX_SLOTS];
   logic signed [COORD_W-1:0] high_y_ff [BOX_SLOTS];
   logic signed [COORD_W-1:0] high_z_ff [BOX_SLOTS];
   logic                      mode_ff   [BOX_SLOTS];
   logic [BOX_SLOTS-1:0]      box_pass;

   // slots, no reset: user must write them before reads (unchecked)
   always_ff @(posedge clock) begin
      for (int i = 0; i < BOX_SLOTS; i++) begin
         if (box_write.valid && (int'(box_write.slot) == i)) begin
            low_x_ff[i]  <= box_write.low_x;
            low_y_ff[i]  <= box_write.low_y;
            low_z_ff[i]  <= box_write.low_z;
            high_x_ff[i] <= box_write.high_x;
            high_y_ff[i] <= box_write.high_y;
            high_z_ff[i] <= box_write.high_z;
            mode_ff[i]   <= box_write.excludes;
         end
      end
   end

   // all boxes tested in parallel; unused slots pass
   always_comb begin
      logic hit;
      for (int i = 0; i < BOX_SLOTS; i++) begin
         hit = (low_x_ff[i] <= point_x) && (point_x <= high_x_ff[i]) &&
               (low_y_ff[i] <= point_y) && (point_y <= high_y_ff[i]) &&
               (low_z_ff[i] <= point_z) && (point_z <= high_z_ff[i]);
         box_pass[i] = (int'(box_count) <= i) || (hit != mode_ff[i]);
      end
   end

   assign keep = &box_pass;

endmodule

// ===== hw/rtl/pbct_checker.sv =====
`include "point_box_crop_transform_assert.svh"

module pbct_checker
   import pbct_pkg::*;
(
   input logic                      clock,
   input logic                      reset,
   input logic                      req_ready,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic signed [COORD_W-1:0] rsp_out_x,
   input logic signed [COORD_W-1:0] rsp_out_y,
   input logic signed [COORD_W-1:0] rsp_out_z
);

   // reset empties the pipeline
   `PBCT_ASSERT_ALWAYS(a_reset_empty, reset, !rsp_valid)
   // with an empty output stage the pipeline always moves
   `PBCT_ASSERT_NOW(a_empty_ready, !rsp_valid, req_ready)
   // a stalled result stays
   `PBCT_ASSERT_NEXT(a_stall_valid, rsp_valid && !rsp_ready, rsp_valid)
   `PBCT_ASSERT_NEXT(a_stall_data, rsp_valid && !rsp_ready,
      $stable(rsp_out_x) && $stable(rsp_out_y) && $stable(rsp_out_z))

endmodule

bind point_box_crop_transform pbct_checker u_pbct_checker (.*);

// ===== test/point_box_crop_transform_tb.sv =====
`timescale 1ns / 100ps

module point_box_crop_transform_tb;
   import pbct_pkg::*;

   // Cycles with no beat on either channel before the run is called hung.
   // The long receiver hold-off below (HOLD_CYCLES) is far shorter, so this leaves margin.
   localparam int STALL_LIMIT = 4000;
   localparam int HOLD_CYCLES = 400;
   localparam int DRAIN_CYCLES = 8;  // pipeline is three stages deep
   localparam int RANDOM_ITEMS = 1800;
   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam logic [1:0] REG_UNKNOWN = 2'd3;
   localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

   typedef struct {
      logic [1:0]         op;
      logic [2:0]         slot;
      logic               excl;
      logic signed [31:0] cx, cy, cz;
      logic signed [31:0] ux, uy, uz;
      logic signed [31:0] off;
   } beat_t;

   typedef struct {
      logic signed [31:0] x, y, z;
   } point_t;

   logic clock = 1'b0;
   logic reset;
   logic req_valid, req_ready;
   logic [1:0] req_op;
   logic [2:0] req_slot;
   logic req_box_excludes;
   logic signed [31:0] req_coord_x, req_coord_y, req_coord_z;
   logic signed [31:0] req_upper_x, req_upper_y, req_upper_z, req_row_offset;
   logic rsp_valid, rsp_ready;
   logic signed [31:0] rsp_out_x, rsp_out_y, rsp_out_z;
   logic csr_write_enable;
   logic [1:0] csr_index;
   logic [3:0] csr_write_data;

   point_box_crop_transform DUT (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Shadow copy of the block's tables and registers.
   logic signed [31:0] bx_lo [3][BOX_SLOTS];
   logic signed [31:0] bx_hi [3][BOX_SLOTS];
   logic               bx_excl [BOX_SLOTS];
   logic signed [31:0] mat [3][3];
   logic signed [31:0] shift [3];
   logic [3:0]         cfg_box_count;
   logic               cfg_filter, cfg_xform;

   point_t kept_points [$];
   int errors = 0;

   // Outputs are sampled mid-cycle so the edge sees settled values, free of
   // any race with the block's own flops.
   logic rr_n, rv_n;
   logic signed [31:0] rx_n, ry_n, rz_n;
   always @(negedge clock) begin
      rr_n = req_ready;
      rv_n = rsp_valid;
      rx_n = rsp_out_x;
      ry_n = rsp_out_y;
      rz_n = rsp_out_z;
   end

   // ---------------------------------------------------------------- predictor
   function automatic logic signed [31:0] xform_row(int r, logic signed [31:0] p [3]);
      logic signed [67:0] acc;
      logic signed [67:0] tot;
      acc = 68'sh8000;  // one half, round half up
      for (int c = 0; c < 3; c++)
         acc += 68'(mat[r][c]) * 68'(p[c]);
      tot = (acc >>> 16) + 68'(shift[r]);
      if (tot > 68'sd2147483647) return S32_MAX;
      if (tot < -68'sd2147483648) return S32_MIN;
      return tot[31:0];
   endfunction

   function automatic bit crop_keeps(logic signed [31:0] p [3]);
      int n;
      bit hit;
      n = (cfg_box_count > BOX_SLOTS) ? BOX_SLOTS : cfg_box_count;
      for (int i = 0; i < n; i++) begin
         hit = 1;
         for (int a = 0; a < 3; a++)
            if (p[a] < bx_lo[a][i] || p[a] > bx_hi[a][i]) hit = 0;
         if (hit && bx_excl[i]) return 0;
         if (!hit && !bx_excl[i]) return 0;
      end
      return 1;
   endfunction

   task automatic predict_beat(beat_t b);
      logic signed [31:0] p [3];
      point_t o;
      p[0] = b.cx; p[1] = b.cy; p[2] = b.cz;
      case (b.op)
         OP_BOX_WRITE: begin
            bx_lo[0][b.slot] = b.cx; bx_lo[1][b.slot] = b.cy; bx_lo[2][b.slot] = b.cz;
            bx_hi[0][b.slot] = b.ux; bx_hi[1][b.slot] = b.uy; bx_hi[2][b.slot] = b.uz;
            bx_excl[b.slot] = b.excl;
         end
         OP_ROW_WRITE: begin
            if (b.slot < ROWS) begin
               for (int c = 0; c < 3; c++) mat[b.slot][c] = p[c];
               shift[b.slot] = b.off;
            end
         end
         OP_POINT: begin
            if (!cfg_filter || crop_keeps(p)) begin
               if (cfg_xform) begin
                  o.x = xform_row(0, p); o.y = xform_row(1, p); o.z = xform_row(2, p);
               end else begin
                  o.x = p[0]; o.y = p[1]; o.z = p[2];
               end
               kept_points = {kept_points, o};
            end
         end
         default: ;  // unused op: no effect
      endcase
   endtask

   // ------------------------------------------------------------------ checker
   always @(posedge clock) begin
      if (!reset && rv_n && rsp_ready) begin
         if (kept_points.size() == 0) begin
            $error("unexpected result beat x=%h y=%h z=%h", rx_n, ry_n, rz_n);
            errors++;
         end else begin
            point_t e;
            e = kept_points.pop_front();
            if (rx_n !== e.x) begin
               $error("out_x expected %h actual %h", e.x, rx_n); errors++;
            end
            if (ry_n !== e.y) begin
               $error("out_y expected %h actual %h", e.y, ry_n); errors++;
            end
            if (rz_n !== e.z) begin
               $error("out_z expected %h actual %h", e.z, rz_n); errors++;
            end
         end
      end
   end

   // ----------------------------------------------------------------- receiver
   // Stall pattern is redrawn at random: always ready, coin flip,
   // or mostly stalled. hold_left forces a long hold-off.
   int hold_left = 0;
   int rx_mode = 0, rx_left = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         if (rx_left == 0) begin
            rx_mode = $urandom_range(0, 2);
            rx_left = $urandom_range(5, 60);
         end
         rx_left--;
         case (rx_mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= 1'($urandom_range(0, 1));
            default: rsp_ready <= ($urandom_range(0, 4) == 0);
         endcase
      end
   end

   // ----------------------------------------------------------------- watchdog
   int quiet = 0;
   always @(posedge clock) begin
      if ((req_valid && rr_n) || (rv_n && rsp_ready) || reset) quiet = 0;
      else quiet++;
      if (quiet >= STALL_LIMIT) begin
         $display("point_box_crop_transform_tb: errors");
         $finish;
      end
   end

   // ------------------------------------------------------------------- sender
   int burst_left = 0;

   task automatic send_item(beat_t b);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
         burst_left = $urandom_range(1, 20);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_op <= b.op;
      req_slot <= b.slot;
      req_box_excludes <= b.excl;
      req_coord_x <= b.cx; req_coord_y <= b.cy; req_coord_z <= b.cz;
      req_upper_x <= b.ux; req_upper_y <= b.uy; req_upper_z <= b.uz;
      req_row_offset <= b.off;
      do @(posedge clock); while (!rr_n);
      predict_beat(b);
   endtask

   // Lower valid and wait until every expected result is back, plus drain time
   // for beats that give no result.
   task automatic wait_idle();
      req_valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (kept_points.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(logic [1:0] idx, logic [3:0] val);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= val;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         REG_BOX_COUNT:        cfg_box_count = val;
         REG_FILTER_ENABLE:    cfg_filter = val[0];
         REG_TRANSFORM_ENABLE: cfg_xform = val[0];
         default: ;
      endcase
   endtask

   function automatic beat_t mk(logic [1:0] op, logic [2:0] slot, logic excl,
                                logic signed [31:0] cx, logic signed [31:0] cy,
                                logic signed [31:0] cz, logic signed [31:0] ux,
                                logic signed [31:0] uy, logic signed [31:0] uz,
                                logic signed [31:0] off);
      beat_t b;
      b.op = op; b.slot = slot; b.excl = excl;
      b.cx = cx; b.cy = cy; b.cz = cz;
      b.ux = ux; b.uy = uy; b.uz = uz; b.off = off;
      return b;
   endfunction

   function automatic beat_t mk_point(logic signed [31:0] x, logic signed [31:0] y,
                                      logic signed [31:0] z);
      return mk(OP_POINT, 3'($urandom), 1'($urandom), x, y, z, $urandom, $urandom,
                $urandom, $urandom);
   endfunction

   // --------------------------------------------------------- random content
   function automatic logic signed [31:0] rand_axis(int a);
      int s;
      longint lo, hi;
      s = $urandom_range(0, BOX_SLOTS - 1);
      lo = bx_lo[a][s];
      hi = bx_hi[a][s];
      case ($urandom_range(0, 3))
         0: return $urandom;
         1: if (lo <= hi) return 32'(lo + longint'($urandom) % (hi - lo + 1));
            else return 32'(lo);
         default: case ($urandom_range(0, 3))  // box faces and just past them
            0: return 32'(lo);
            1: return 32'(hi);
            2: return 32'(lo - 1);
            default: return 32'(hi + 1);
         endcase
      endcase
   endfunction

   function automatic logic signed [31:0] rand_coef();
      case ($urandom_range(0, 5))
         0: return $urandom;
         1: return Q_ONE;
         2: return 0;
         default: return $signed(32'($urandom_range(0, 32'h3_FFFF))) - 32'sh2_0000;
      endcase
   endfunction

   function automatic beat_t rand_beat();
      beat_t b;
      int pick;
      logic signed [31:0] c, w;
      pick = $urandom_range(0, 99);
      b = mk(OP_POINT, 3'($urandom), 1'($urandom), $urandom, $urandom, $urandom,
             $urandom, $urandom, $urandom, $urandom);
      if (pick < 75) begin
         b.cx = rand_axis(0); b.cy = rand_axis(1); b.cz = rand_axis(2);
      end else if (pick < 85) begin
         // box around a random center, sometimes inverted (empty)
         b.op = OP_BOX_WRITE;
         c = $urandom; w = $urandom_range(0, 32'h00FF_FFFF);
         b.cx = c - w; b.ux = c + w;
         c = $urandom; w = $urandom_range(0, 32'h00FF_FFFF);
         b.cy = c - w; b.uy = c + w;
         c = $urandom; w = $urandom_range(0, 32'h00FF_FFFF);
         b.cz = c - w; b.uz = c + w;
         if ($urandom_range(0, 9) == 0) b.uy = b.cy - 1;
      end else if (pick < 93) begin
         b.op = OP_ROW_WRITE;
         b.slot = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(3, 7))
                                               : 3'($urandom_range(0, 2));
         b.cx = rand_coef(); b.cy = rand_coef(); b.cz = rand_coef();
         if ($urandom_range(0, 1)) b.off = $signed(32'($urandom_range(0, 32'hFFFFF))) - 32'sh80000;
      end else if (pick < 97) begin
         b.op = OP_UNUSED;
      end
      return b;
   endfunction

   // ---------------------------------------------------------------- tests
   task automatic test_reset_defaults();
      // identity transform, no boxes: extremes pass through unchanged
      send_item(mk_point(S32_MAX, S32_MIN, 0));
      send_item(mk_point(S32_MIN, -1, S32_MAX));
      send_item(mk_point(-1, 1, Q_ONE));
      send_item(mk(OP_UNUSED, 3'd7, 1'b1, S32_MAX, S32_MAX, S32_MAX, 0, 0, 0, S32_MAX));
      send_item(mk(OP_ROW_WRITE, 3'd5, 1'b0, S32_MAX, S32_MAX, S32_MAX, 0, 0, 0,
                   S32_MAX));
      send_item(mk_point(32'sh1234_5678, 32'sh8765_4321, -2));
   endtask

   task automatic test_box_tables();
      // every slot loaded; slot 6 empty (low > high on x); full-range include
      for (int s = 0; s < BOX_SLOTS; s++) begin
         if (s == 0)
            send_item(mk(OP_BOX_WRITE, 3'(s), 1'b0, S32_MIN, S32_MIN, S32_MIN,
                         S32_MAX, S32_MAX, S32_MAX, 0));
         else if (s == 6)
            send_item(mk(OP_BOX_WRITE, 3'(s), 1'b1, 100, -100, -100, 99, 100, 100, 0));
         else
            send_item(mk(OP_BOX_WRITE, 3'(s), 1'(s % 2), -s * 1000, -s * 1000,
                         -s * 1000, s * 1000, s * 1000, s * 1000, 0));
      end
      wait_idle();
      csr_write(REG_BOX_COUNT, 4'(BOX_SLOTS));
      send_item(mk_point(1000, 1000, 1000));     // on face of exclude box 1
      send_item(mk_point(2000, -2000, 2000));    // corner of include box 2
      send_item(mk_point(7001, 0, 0));           // just outside exclude box 7
      send_item(mk_point(100, 0, 0));            // in the empty box's x-range edge
      send_item(mk_point(1500, 1500, 1500));
      wait_idle();
      csr_write(REG_BOX_COUNT, 4'hF);            // above slot count: saturates
      send_item(mk_point(1500, 1500, 1500));
      send_item(mk_point(0, 0, 0));
      wait_idle();
   endtask

   task automatic test_transform_rows();
      csr_write(REG_BOX_COUNT, 4'd0);
      // round half up on row 0, saturate high on row 1, low on row 2
      send_item(mk(OP_ROW_WRITE, 3'd0, 1'b0, 32'sh8000, 0, 0, 0, 0, 0, 0));
      send_item(mk(OP_ROW_WRITE, 3'd1, 1'b0, S32_MAX, S32_MAX, S32_MAX, 0, 0, 0,
                   S32_MAX));
      send_item(mk(OP_ROW_WRITE, 3'd2, 1'b0, S32_MIN, S32_MIN, S32_MIN, 0, 0, 0,
                   S32_MIN));
      send_item(mk_point(1, 1, 1));
      send_item(mk_point(-1, -1, -1));
      send_item(mk_point(S32_MAX, S32_MAX, S32_MAX));
      send_item(mk_point(S32_MIN, S32_MIN, S32_MIN));
      send_item(mk_point(3, 0, 0));
      wait_idle();
   endtask

   task automatic test_register_sweep();
      csr_write(REG_FILTER_ENABLE, 4'd0);
      csr_write(REG_TRANSFORM_ENABLE, 4'd0);
      csr_write(REG_BOX_COUNT, 4'(BOX_SLOTS));
      csr_write(REG_UNKNOWN, 4'hF);              // unknown index: no effect
      send_item(mk_point(S32_MAX, 0, S32_MIN));
      send_item(mk_point(1000, 1000, 1000));
      wait_idle();
      csr_write(REG_FILTER_ENABLE, 4'd1);
      csr_write(REG_TRANSFORM_ENABLE, 4'd1);
   endtask

   task automatic test_random_phases();
      int sent = 0;
      while (sent < RANDOM_ITEMS) begin
         case ($urandom_range(0, 3))
            0: csr_write(REG_BOX_COUNT, 4'd0);
            1: csr_write(REG_BOX_COUNT, 4'(BOX_SLOTS));
            default: csr_write(REG_BOX_COUNT, 4'($urandom_range(0, 15)));
         endcase
         csr_write(REG_FILTER_ENABLE, 4'($urandom_range(0, 3) != 0));
         csr_write(REG_TRANSFORM_ENABLE, 4'($urandom_range(0, 3) != 0));
         for (int i = 0; i < 150; i++) begin
            beat_t b;
            b = rand_beat();
            send_item(b);
            sent++;
         end
         wait_idle();  // sender pauses until all results are back
      end
   endtask

   task automatic test_backpressure();
      // receiver holds off long enough for the pipeline to fill and stall input
      csr_write(REG_FILTER_ENABLE, 4'd0);
      hold_left = HOLD_CYCLES;
      for (int i = 0; i < 60; i++) send_item(mk_point($urandom, $urandom, $urandom));
      wait_idle();
   endtask

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_op <= OP_POINT; req_slot <= '0; req_box_excludes <= 1'b0;
      req_coord_x <= 0; req_coord_y <= 0; req_coord_z <= 0;
      req_upper_x <= 0; req_upper_y <= 0; req_upper_z <= 0; req_row_offset <= 0;
      csr_write_enable <= 1'b0; csr_index <= REG_BOX_COUNT; csr_write_data <= '0;
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) mat[r][c] = (r == c) ? Q_ONE : 0;
         shift[r] = 0;
      end
      cfg_box_count = 0; cfg_filter = 1; cfg_xform = 1;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      wait_idle();
      test_box_tables();
      test_transform_rows();
      test_register_sweep();
      test_backpressure();
      test_random_phases();

      wait_idle();
      if (errors == 0)
         $display("point_box_crop_transform_tb: clean");
      else
         $display("point_box_crop_transform_tb: errors");
      $finish;
   end

endmodule
